@@ sv/tacs_pkg.sv @@
// Package with the shared types and constants of the tag access control store.
package tacs_pkg;

  localparam int unsigned TACS_TAG_SLOTS = 32;
  localparam int unsigned TAG_W = 32;
  localparam logic [TAG_W-1:0] ERASED_ID = {TAG_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_START       = 2'd0,
    MODE_WAIT_MASTER = 2'd1,
    MODE_PROGRAM     = 2'd2,
    MODE_NORMAL      = 2'd3
  } mode_t;

  // Query that walks down the chain of slot cells, one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic             found;
    logic             free_seen;
    logic             first;
  } tacs_query_t;

endpackage

@@ sv/tag_access_control_store_core.sv @@
// Top level of the tag access control store: mode control, master ID and slot chain.
//
// Each input beat is one tag poll and yields exactly one result beat. Polls that need no
// store lookup (start mode, waiting for the master, no tag, the master tag in normal mode)
// go from acceptance straight to the result hand-off. Polls that look up the store send a
// query down the chain of slot cells one cell per clock, and an enrollment write lands in
// the cycle the query leaves the last cell. A new poll is accepted once the previous one
// has placed its result in the output register, even while that result is still waiting
// to be taken. Every slot has a valid bit cleared by reset, so the store reads as erased
// right out of reset with no clearing pass. A slot holding zero or all ones counts as
// empty; slot 0 holds the master and is never used for enrollment.
module tag_access_control_store_core
  import tacs_pkg::*;
#(
  parameter int unsigned TAG_SLOTS = TACS_TAG_SLOTS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [TAG_W-1:0] in_tag_id,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_unlock,
  output logic [1:0]       out_mode,
  output logic             out_enrolled,
  output logic             out_store_full,
  output logic             out_already_known
);

  // Sequencer states: idle and accepting, scan in the chain, result hand-off.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t           st_r, st_nxt;
  mode_t            mode_r, mode_nxt;
  logic [TAG_W-1:0] master_r, master_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic             launch_r, launch_nxt;

  // Pending result of the poll in progress.
  logic res_unlock_r, res_unlock_nxt;
  logic res_enr_r, res_enr_nxt;
  logic res_full_r, res_full_nxt;
  logic res_known_r, res_known_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic       out_unlock_r, out_unlock_nxt;
  logic [1:0] out_mode_r, out_mode_nxt;
  logic       out_enr_r, out_enr_nxt;
  logic       out_full_r, out_full_nxt;
  logic       out_known_r, out_known_nxt;

  logic             accept;
  logic             commit;
  logic             master_wr;
  logic             out_free;
  logic [TAG_W-1:0] wr_data;

  tacs_query_t          chain [TAG_SLOTS+1];
  logic [TAG_SLOTS-1:0] claim_vec;
  logic [TAG_SLOTS-1:0] wr_vec;

  assign in_ready = (st_r == ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  // The master is written in the accepting cycle, enrollment from the held tag.
  assign wr_data = (st_r == ST_IDLE) ? in_tag_id : tag_r;

  // The query enters the head of the chain in the cycle after the poll is accepted.
  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = launch_r;
    chain[0].tag       = tag_r;
    chain[0].first     = 1'b1;
  end

  for (genvar i = 0; i < TAG_SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign wr_vec[i] = master_wr | (commit & claim_vec[i]);
    end else begin : g_body
      assign wr_vec[i] = commit & claim_vec[i];
    end

    tacs_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .query_i (chain[i]),
      .query_o (chain[i+1]),
      .wr_en   (wr_vec[i]),
      .wr_data (wr_data),
      .claim_o (claim_vec[i])
    );
  end

  always_comb begin
    st_nxt         = st_r;
    mode_nxt       = mode_r;
    master_nxt     = master_r;
    tag_nxt        = tag_r;
    launch_nxt     = 1'b0;
    res_unlock_nxt = res_unlock_r;
    res_enr_nxt    = res_enr_r;
    res_full_nxt   = res_full_r;
    res_known_nxt  = res_known_r;
    commit         = 1'b0;
    master_wr      = 1'b0;

    out_valid_nxt  = out_valid_r & ~out_ready;
    out_unlock_nxt = out_unlock_r;
    out_mode_nxt   = out_mode_r;
    out_enr_nxt    = out_enr_r;
    out_full_nxt   = out_full_r;
    out_known_nxt  = out_known_r;

    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          tag_nxt        = in_tag_id;
          res_unlock_nxt = 1'b0;
          res_enr_nxt    = 1'b0;
          res_full_nxt   = 1'b0;
          res_known_nxt  = 1'b0;
          st_nxt         = ST_FIN;
          unique case (mode_r)
            MODE_START: begin
              // The first poll only decides whether a master must be learned.
              mode_nxt = (master_r == ERASED_ID) ? MODE_WAIT_MASTER : MODE_NORMAL;
            end
            MODE_WAIT_MASTER: begin
              if (in_tag_id != '0) begin
                master_nxt  = in_tag_id;
                master_wr   = 1'b1;
                res_enr_nxt = 1'b1;
                mode_nxt    = MODE_NORMAL;
              end
            end
            MODE_PROGRAM: begin
              if (in_tag_id != '0) begin
                launch_nxt = 1'b1;
                st_nxt     = ST_SCAN;
              end
            end
            MODE_NORMAL: begin
              if (in_tag_id != '0) begin
                if (in_tag_id == master_r) begin
                  mode_nxt = MODE_PROGRAM;
                end else begin
                  launch_nxt = 1'b1;
                  st_nxt     = ST_SCAN;
                end
              end
            end
            default: begin
              mode_nxt = MODE_START;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (chain[TAG_SLOTS].valid) begin
          st_nxt = ST_FIN;
          if (mode_r == MODE_PROGRAM) begin
            // Enroll into the slot that claimed itself as the first empty one.
            res_known_nxt = chain[TAG_SLOTS].found;
            res_enr_nxt   = ~chain[TAG_SLOTS].found & chain[TAG_SLOTS].free_seen;
            res_full_nxt  = ~chain[TAG_SLOTS].found & ~chain[TAG_SLOTS].free_seen;
            commit        = ~chain[TAG_SLOTS].found & chain[TAG_SLOTS].free_seen;
            mode_nxt      = MODE_NORMAL;
          end else begin
            res_known_nxt  = chain[TAG_SLOTS].found;
            res_unlock_nxt = chain[TAG_SLOTS].found;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_unlock_nxt = res_unlock_r;
          out_mode_nxt   = mode_r;
          out_enr_nxt    = res_enr_r;
          out_full_nxt   = res_full_r;
          out_known_nxt  = res_known_r;
          st_nxt         = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      mode_r      <= MODE_START;
      master_r    <= ERASED_ID;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      mode_r      <= mode_nxt;
      master_r    <= master_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r        <= tag_nxt;
    res_unlock_r <= res_unlock_nxt;
    res_enr_r    <= res_enr_nxt;
    res_full_r   <= res_full_nxt;
    res_known_r  <= res_known_nxt;
    out_unlock_r <= out_unlock_nxt;
    out_mode_r   <= out_mode_nxt;
    out_enr_r    <= out_enr_nxt;
    out_full_r   <= out_full_nxt;
    out_known_r  <= out_known_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_unlock        = out_unlock_r;
  assign out_mode          = out_mode_r;
  assign out_enrolled      = out_enr_r;
  assign out_store_full    = out_full_r;
  assign out_already_known = out_known_r;

  // An enrollment writes exactly one slot.
  a_commit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> $onehot(claim_vec))
    else $error("enrollment write without exactly one claimed slot");

  // A query only leaves the chain while the sequencer waits for it.
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chain[TAG_SLOTS].valid |-> (st_r == ST_SCAN))
    else $error("scan result outside of scan state");

  // The chain is idle whenever a new poll can be accepted.
  a_chain_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!launch_r && !chain[TAG_SLOTS].valid))
    else $error("query in flight while accepting a poll");

  // A delivered result never reports both an enrollment and a full store.
  a_enr_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_enr_r && out_full_r))
    else $error("result reports enrollment and full store together");

  // An unlock only happens in normal mode and always with a match.
  a_unlock_normal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_unlock_r) |-> (out_mode_r == MODE_NORMAL && out_known_r))
    else $error("unlock outside of normal mode or without a match");

endmodule

@@ sv/tacs_cell.sv @@
// One slot of the ID store, with its stage of the scan chain.
module tacs_cell
  import tacs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  tacs_query_t      query_i,
  output tacs_query_t      query_o,
  input  logic             wr_en,
  input  logic [TAG_W-1:0] wr_data,
  output logic             claim_o
);

  logic [TAG_W-1:0] slot_r;
  logic             valid_r;
  logic             claim_r;
  logic             claim_nxt;
  tacs_query_t      query_r;
  tacs_query_t      query_nxt;
  logic [TAG_W-1:0] stored;
  logic             hit;
  logic             empty;

  // A slot never written reads as erased.
  assign stored = valid_r ? slot_r : ERASED_ID;
  assign hit    = (stored == query_i.tag);
  assign empty  = (stored == '0) || (stored == ERASED_ID);

  always_comb begin
    query_nxt           = query_i;
    query_nxt.found     = query_i.found | hit;
    query_nxt.free_seen = query_i.free_seen | (empty & ~query_i.first);
    query_nxt.first     = 1'b0;
    claim_nxt           = claim_r;
    if (query_i.valid) begin
      claim_nxt = empty & ~query_i.free_seen & ~query_i.first & ~query_i.found;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      claim_r <= 1'b0;
      query_r <= '0;
    end else begin
      claim_r <= claim_nxt;
      query_r <= query_nxt;
      if (wr_en) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r <= wr_data;
    end
  end

  assign query_o = query_r;
  assign claim_o = claim_r;

endmodule
